// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked property, disabled while in reset
`define CHK_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// checked property, also during reset
`define CHK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

// ===== hw/rtl/rtpv_pkg.sv =====
// shared types and constants for the running temporal pixel variance block
package rtpv_pkg;
  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;
  localparam int MAX_FRAMES = 65535;
  localparam int NCHAN      = 3;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SUM_W      = 24;
  localparam int SQ_W       = 32;
  localparam int ENT_W      = SUM_W + SQ_W;
  localparam int WORD_W     = NCHAN * ENT_W;
  localparam int PROD_W     = 48;
  localparam int CFG_W      = 10;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPD, S_MULA, S_MULB, S_SUB, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic upd;
    logic mula;
    logic mulb;
    logic sub;
    logic div;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic ch_last;
  } sts_t;
endpackage

// ===== hw/rtl/rtpv_ctrl.sv =====
// controller state machine for the variance block
module rtpv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rtpv_pkg::sts_t sts,
  output rtpv_pkg::cmd_t cmd
);
  import rtpv_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mula   = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mulb   = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_next = sts.ch_last ? S_OUT : S_MULA;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/rtpv_dp.sv =====
// datapath: accumulator memory, position counters and variance arithmetic
module rtpv_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rtpv_pkg::CFG_W-1:0]    cfg_data,
  input  logic [7:0]                    chan_red,
  input  logic [7:0]                    chan_green,
  input  logic [7:0]                    chan_blue,
  input  rtpv_pkg::cmd_t                cmd,
  output rtpv_pkg::sts_t                sts,
  output logic [7:0]                    var_red,
  output logic [7:0]                    var_green,
  output logic [7:0]                    var_blue,
  output logic                          frame_end
);
  import rtpv_pkg::*;

  logic [9:0]        frame_width;
  logic [8:0]        frame_height;
  logic [9:0]        w_eff;
  logic [8:0]        h_eff;
  logic [9:0]        col;
  logic [8:0]        row;
  logic [15:0]       frames_seen;
  logic              frames_full;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        pix [NCHAN];
  logic [SUM_W-1:0]  s_reg [NCHAN];
  logic [SQ_W-1:0]   sq_reg [NCHAN];
  logic [SUM_W-1:0]  s_new [NCHAN];
  logic [SQ_W-1:0]   sq_new [NCHAN];
  logic [7:0]        res [NCHAN];
  logic [1:0]        ch;
  logic [15:0]       n_cur;
  logic [31:0]       den;
  logic [PROD_W-1:0] p1;
  logic [PROD_W-1:0] p2;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] den_sh;
  logic [3:0]        k;
  logic [7:0]        q;
  logic              ge;
  logic              col_wrap;
  logic              row_wrap;

  // zero acts as one, oversize acts as the maximum
  assign w_eff = (frame_width == '0) ? 10'd1 :
                 (frame_width > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height == '0) ? 9'd1 :
                 (frame_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : frame_height;

  assign rd_addr  = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  assign col_wrap = (11'(col) + 11'd1) >= 11'(w_eff);
  assign row_wrap = (10'(row) + 10'd1) >= 10'(h_eff);

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      s_new[c]  = rdata[c*ENT_W +: SUM_W] + SUM_W'(pix[c]);
      sq_new[c] = rdata[c*ENT_W+SUM_W +: SQ_W] + SQ_W'(16'(pix[c]) * 16'(pix[c]));
      wdata[c*ENT_W +: SUM_W]       = s_new[c];
      wdata[c*ENT_W+SUM_W +: SQ_W]  = sq_new[c];
    end
    if (cmd.clr) wdata = '0;
  end

  assign we    = cmd.clr | (cmd.upd & ~frames_full);
  assign waddr = cmd.clr ? clr_addr : pix_addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.accept) rdata <= mem[rd_addr];
  end

  // configuration and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 10'(MAX_WIDTH);
      frame_height <= 9'(MAX_HEIGHT);
      col          <= '0;
      row          <= '0;
      frames_seen  <= 16'd1;
      frames_full  <= 1'b0;
      clr_addr     <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_WIDTH) frame_width <= cfg_data;
      if (cfg_we && cfg_index == CFG_HEIGHT) frame_height <= cfg_data[8:0];
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.upd) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row <= '0;
            if (frames_seen >= 16'(MAX_FRAMES)) frames_full <= 1'b1;
            else frames_seen <= frames_seen + 16'd1;
          end else begin
            row <= row + 9'd1;
          end
        end else begin
          col <= col + 10'd1;
        end
      end
    end
  end

  assign sts.clr_done = (clr_addr == ADDR_W'(DEPTH - 1));

  assign den_sh = PROD_W'(den) << k;
  assign ge     = rem >= den_sh;

  always_comb begin
    q = res[ch];
    if (k == 4'd8) begin
      if (rem == '0) q = 8'd0;
      else if (ge) q = 8'd255;
    end else if (ge) begin
      q[k[2:0]] = 1'b1;
    end
  end

  assign sts.div_done = (k == 4'd0) || (k == 4'd8 && (rem == '0 || ge));
  assign sts.ch_last  = (ch == 2'(NCHAN - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix[0]   <= chan_red;
      pix[1]   <= chan_green;
      pix[2]   <= chan_blue;
      pix_addr <= rd_addr;
    end
    if (cmd.upd) begin
      for (int c = 0; c < NCHAN; c++) begin
        s_reg[c]  <= frames_full ? rdata[c*ENT_W +: SUM_W] : s_new[c];
        sq_reg[c] <= frames_full ? rdata[c*ENT_W+SUM_W +: SQ_W] : sq_new[c];
      end
      n_cur     <= frames_seen;
      den       <= 32'(frames_seen) * 32'(frames_seen - 16'd1);
      frame_end <= col_wrap & row_wrap;
      ch        <= '0;
    end
    if (cmd.mula) p1 <= PROD_W'(n_cur) * PROD_W'(sq_reg[ch]);
    if (cmd.mulb) p2 <= PROD_W'(s_reg[ch]) * PROD_W'(s_reg[ch]);
    if (cmd.sub) begin
      rem <= (n_cur < 16'd2 || p2 >= p1) ? '0 : p1 - p2;
      k   <= 4'd8;
      res[ch] <= '0;
    end
    if (cmd.div) begin
      if (k != 4'd8 && ge) rem <= rem - den_sh;
      if (k == 4'd8) res[ch] <= q;
      else res[ch] <= q;
      if (sts.div_done) begin
        if (!sts.ch_last) ch <= ch + 2'd1;
      end else begin
        k <= k - 4'd1;
      end
    end
  end

  assign var_red   = res[0];
  assign var_green = res[1];
  assign var_blue  = res[2];
endmodule

// ===== hw/rtl/running_temporal_pixel_variance.sv =====
// top level: running per-pixel temporal variance of an rgb stream
// one transaction at a time: the result is made after input acceptance by the update state,
// then per channel a multiplier path shared by the channels (MULA, MULB, SUB) and a restoring divider
// with an 8-bit quotient; a new pixel is taken only after the previous result has been accepted
// reset: synchronous; a clearing pass zeroes the accumulator memory,
// input ready stays low until it ends; frame size returns to 640 x 480
module running_temporal_pixel_variance (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] chan_red,
  input  logic [7:0] chan_green,
  input  logic [7:0] chan_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] var_red,
  output logic [7:0] var_green,
  output logic [7:0] var_blue,
  output logic       frame_end
);
  import rtpv_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  rtpv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rtpv_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .chan_red, .chan_green, .chan_blue,
    .cmd, .sts, .var_red, .var_green, .var_blue, .frame_end
  );

  `CHK_ALWAYS(a_excl, clk, !(in_ready && out_valid), "ready and result valid together")
  `CHK_PROP(a_one_out, clk, rst, (out_valid && out_ready) |=> !out_valid, "result repeated")
  `CHK_PROP(a_busy, clk, rst, (in_valid && in_ready) |=> !in_ready, "second item taken early")
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the running temporal pixel variance block
`timescale 1ns / 1ps

module testbench;
  import rtpv_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int IDLE_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } variance_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         known;
    logic [7:0] red_var;
  } pixel_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_WIDTH;
  logic [9:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] chan_red = '0;
  logic [7:0] chan_green = '0;
  logic [7:0] chan_blue = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] var_red;
  logic [7:0] var_green;
  logic [7:0] var_blue;
  logic       frame_end;

  running_temporal_pixel_variance u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: sparse per-pixel sums, keyed by pixel address and channel
  logic [23:0] sum_store [int];
  logic [31:0] sq_store [int];
  int          col_pos, row_pos;
  int          frames_seen;
  bit          frames_full;
  int          width_reg, height_reg;

  variance_t expected_q[$];
  logic [7:0] pinned_red_q[$];
  bit         pinned_known_q[$];

  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("[%0t] result %0d: %s got %0d want %0d", $realtime, n_recv, what, got, want);
  endtask

  function automatic int clamp_dim(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] running_variance(input logic [63:0] s, input logic [63:0] sq,
                                                  input logic [63:0] n);
    logic [63:0] num, q;
    if (n < 2) return 8'd0;
    num = n * sq;
    if (s * s >= num) return 8'd0;
    q = (num - s * s) / (n * (n - 1));
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic variance_t predict_variance(input pixel_t px);
    variance_t  r;
    logic [7:0] x [3];
    logic [7:0] v [3];
    int         w, h, base, a;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    base = NCHAN * (((row_pos < MAX_HEIGHT) ? row_pos : MAX_HEIGHT - 1) * MAX_WIDTH
                    + ((col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1));
    x[0] = px.red; x[1] = px.green; x[2] = px.blue;
    for (int k = 0; k < NCHAN; k++) begin
      a = base + k;
      if (!sum_store.exists(a)) begin
        sum_store[a] = '0;
        sq_store[a] = '0;
      end
      if (!frames_full) begin
        sum_store[a] = sum_store[a] + 24'(x[k]);
        sq_store[a] = sq_store[a] + 32'(x[k]) * 32'(x[k]);
      end
      v[k] = running_variance(64'(sum_store[a]), 64'(sq_store[a]), 64'(frames_seen));
    end
    r.red = v[0]; r.green = v[1]; r.blue = v[2];
    r.last = 1'b0;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        r.last = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    if (r.last) begin
      if (frames_seen >= MAX_FRAMES) frames_full = 1'b1;
      else frames_seen++;
    end
    return r;
  endfunction

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[9:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = value & 10'h3ff;
    else height_reg = value & 9'h1ff;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays up after a transaction so that back-to-back items need one assignment
  task automatic send_pixel(input pixel_t px, input bit known, input logic [7:0] red_var);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    chan_red <= px.red;
    chan_green <= px.green;
    chan_blue <= px.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_variance(px));
    pinned_known_q.push_back(known);
    pinned_red_q.push_back(red_var);
    n_sent++;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(0, 4))
      0: begin px.red = 8'd0; px.green = 8'd255; px.blue = 8'($urandom); end
      1: begin
        px.red = 8'd100 + 8'($urandom_range(0, 6));
        px.green = 8'd50 + 8'($urandom_range(0, 30));
        px.blue = 8'd200 + 8'($urandom_range(0, 3));
      end
      default: begin
        px.red = 8'($urandom); px.green = 8'($urandom); px.blue = 8'($urandom);
      end
    endcase
    return px;
  endfunction

  // sink side: random backpressure, compare against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", var_red, 0);
        end else begin
          variance_t e;
          bit        k;
          logic [7:0] pr;
          e = expected_q.pop_front();
          k = pinned_known_q.pop_front();
          pr = pinned_red_q.pop_front();
          if (k && var_red !== pr) report("var_red (table)", var_red, pr);
          if (var_red !== e.red) report("var_red", var_red, e.red);
          if (var_green !== e.green) report("var_green", var_green, e.green);
          if (var_blue !== e.blue) report("var_blue", var_blue, e.blue);
          if (frame_end !== e.last) report("frame_end", frame_end, e.last);
        end
        n_recv++;
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired: sent %0d received %0d", n_sent, n_recv);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  pixel_row_t directed_rows[] = '{
    // first frame on a 2x2 frame always answers zero
    '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{8'd0,   8'd255, 8'd128, 1'b1, 8'd0},
    '{8'd255, 8'd0,   8'd1,   1'b1, 8'd0},
    // second frame: 0 then 255 on the first pixel -> variance saturates
    '{8'd255, 8'd0,   8'd0,   1'b1, 8'd255},
    '{8'd255, 8'd255, 8'd254, 1'b1, 8'd0},
    '{8'd0,   8'd250, 8'd128, 1'b1, 8'd0},
    '{8'd250, 8'd3,   8'd5,   1'b0, 8'd0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 8'd0},
    '{8'd170, 8'd85,  8'd15,  1'b0, 8'd0},
    '{8'd128, 8'd64,  8'd32,  1'b0, 8'd0},
    '{8'd16,  8'd8,   8'd4,   1'b0, 8'd0}
  };

  initial begin
    pixel_t px;
    int     n_rand;
    sum_store.delete();
    sq_store.delete();
    col_pos = 0; row_pos = 0; frames_seen = 1; frames_full = 1'b0;
    width_reg = 640; height_reg = 480;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    foreach (directed_rows[i]) begin
      px.red = directed_rows[i].red;
      px.green = directed_rows[i].green;
      px.blue = directed_rows[i].blue;
      send_pixel(px, directed_rows[i].known, directed_rows[i].red_var);
    end
    wait_drained();

    // out-of-range and extreme sizes: zero acts as one, overlarge clamps
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    repeat (6) send_pixel(random_pixel(), 1'b0, 8'd0);
    wait_drained();
    write_reg(CFG_WIDTH, 1023);
    write_reg(CFG_HEIGHT, 1);
    repeat (20) send_pixel(random_pixel(), 1'b0, 8'd0);
    wait_drained();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 511);
    repeat (10) send_pixel(random_pixel(), 1'b0, 8'd0);
    wait_drained();
    // mid-frame resize from a tall narrow frame to the full 640 x 480 size
    write_reg(CFG_HEIGHT, 480);
    write_reg(CFG_WIDTH, 640);
    repeat (5) send_pixel(random_pixel(), 1'b0, 8'd0);
    wait_drained();

    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      int w, h, cnt;
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1023);
      if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 511);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      cnt = $urandom_range(20, 120);
      quiet = (n_rand > N_RANDOM * 4 / 5);
      for (int i = 0; i < cnt; i++) send_pixel(random_pixel(), 1'b0, 8'd0);
      n_rand += cnt;
      wait_drained();
    end
    stim_done = 1'b1;

    $display("sent %0d pixels over %0d frames of varying size, %0d variances checked",
             n_sent, frames_seen, n_recv);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d expectations left", errors, expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
